// File: rtl/core/yolo_box_match_iou_assert.svh
// assertion helpers included by the top core file
`ifndef YOLO_BOX_MATCH_IOU_ASSERT_SVH
`define YOLO_BOX_MATCH_IOU_ASSERT_SVH

// same-cycle implication, checked on every rising edge outside reset
`define YBM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("yolo_box_match_iou: implication violated");

// next-cycle implication
`define YBM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("yolo_box_match_iou: next-cycle implication violated");

`endif

// File: rtl/core/ybm_pkg.sv
package ybm_pkg;

  localparam int MUL_W       = 18;
  localparam int PROD_W      = 2 * MUL_W;
  localparam int DIV_R_W     = 34;
  localparam int DIV_N_W     = 17;
  localparam int STEP_W      = 5;
  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;
  localparam int MAX_BOXES_D = 16;

  localparam logic [STEP_W-1:0] SIDE_STEPS = STEP_W'(DIV_N_W);
  localparam logic [STEP_W-1:0] IOU_STEPS  = STEP_W'(15);

  localparam logic [5:0]  GRID_RESET = 6'd7;
  localparam logic [14:0] ONE_Q14    = 15'd16384;
  localparam logic [22:0] DIST_START = 23'd6553600;

  // register word index (paddr[2])
  localparam logic REG_GRID_SIDE = 1'b0;
  localparam logic REG_SQRT_MODE = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_DIVX, S_DIVY, S_SQW, S_SQH, S_OVL, S_MINT, S_MPA,
    S_MTA, S_UNION, S_DIVQ, S_DX, S_DY, S_DW, S_DH, S_DECIDE
  } state_t;

  typedef struct packed {
    logic               op;
    logic signed [15:0] box_x;
    logic signed [15:0] box_y;
    logic signed [15:0] box_w;
    logic signed [15:0] box_h;
    logic               last_box;
  } item_t;

  typedef struct packed {
    logic [3:0]  chosen_index;
    logic [14:0] best_overlap;
    logic        matched_by_overlap;
    logic        bad_union;
  } result_t;

  function automatic logic [MUL_W-1:0] mag(input logic signed [MUL_W-1:0] v);
    return v[MUL_W-1] ? -v : v;
  endfunction

  // interval overlap at doubled scale
  function automatic logic signed [18:0] ovl(input logic signed [15:0] c1,
                                            input logic signed [15:0] w1,
                                            input logic signed [15:0] c2,
                                            input logic signed [15:0] w2);
    logic signed [17:0] l1, l2, r1, r2, lft, rgt;
    l1 = {c1[15], c1, 1'b0} - {{2{w1[15]}}, w1};
    r1 = {c1[15], c1, 1'b0} + {{2{w1[15]}}, w1};
    l2 = {c2[15], c2, 1'b0} - {{2{w2[15]}}, w2};
    r2 = {c2[15], c2, 1'b0} + {{2{w2[15]}}, w2};
    lft = (l1 > l2) ? l1 : l2;
    rgt = (r1 < r2) ? r1 : r2;
    return {rgt[17], rgt} - {lft[17], lft};
  endfunction

endpackage

// File: rtl/core/ybm_mul.sv
module ybm_mul (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [ybm_pkg::MUL_W-1:0]   a,
  input  logic [ybm_pkg::MUL_W-1:0]   b,
  output logic                        busy,
  output logic                        done,
  output logic [ybm_pkg::PROD_W-1:0]  prod
);
  import ybm_pkg::*;

  logic [MUL_W-1:0]  mcand;
  logic [MUL_W-1:0]  hi;
  logic [MUL_W-1:0]  lo;
  logic [STEP_W-1:0] cnt;
  logic [MUL_W:0]    sum;

  // one multiplier bit per cycle, shift-add
  assign sum  = {1'b0, hi} + (lo[0] ? {1'b0, mcand} : '0);
  assign prod = {hi, lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= STEP_W'(MUL_W - 1);
      end else if (busy) begin
        cnt <= cnt - STEP_W'(1);
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand <= a;
      hi    <= '0;
      lo    <= b;
    end else if (busy) begin
      hi <= sum[MUL_W:1];
      lo <= {sum[0], lo[MUL_W-1:1]};
    end
  end

endmodule

// File: rtl/core/ybm_div.sv
module ybm_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [ybm_pkg::DIV_R_W-1:0]  rem_init,
  input  logic [ybm_pkg::DIV_R_W-1:0]  den,
  input  logic [ybm_pkg::DIV_N_W-1:0]  num,
  input  logic [ybm_pkg::STEP_W-1:0]   steps,
  output logic                         busy,
  output logic                         done,
  output logic [ybm_pkg::DIV_N_W-1:0]  quo
);
  import ybm_pkg::*;

  logic [DIV_R_W-1:0] rem;
  logic [DIV_R_W-1:0] dsr;
  logic [DIV_N_W-1:0] nsh;
  logic [STEP_W-1:0]  cnt;
  logic [DIV_R_W:0]   trial;
  logic [DIV_R_W:0]   diff;
  logic               ge;

  // restoring division, one quotient bit per cycle
  assign trial = {rem, nsh[DIV_N_W-1]};
  assign diff  = trial - {1'b0, dsr};
  assign ge    = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= steps - STEP_W'(1);
      end else if (busy) begin
        cnt <= cnt - STEP_W'(1);
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= rem_init;
      dsr <= den;
      nsh <= num;
      quo <= '0;
    end else if (busy) begin
      rem <= ge ? diff[DIV_R_W-1:0] : trial[DIV_R_W-1:0];
      nsh <= {nsh[DIV_N_W-2:0], 1'b0};
      quo <= {quo[DIV_N_W-2:0], ge};
    end
  end

endmodule

// File: rtl/core/yolo_box_match_iou.sv
// Responsible-box choice for one grid cell, scored by center-form IoU.
// Item channel (item_valid/item_stall/item): op 0 loads the truth box and
// starts a new run, op 1 scores one predicted box. item_stall is high while
// an item is being worked on; one item is handled at a time.
// Result channel (result_valid/result_stall/result): one result on the last
// box of a run, or on the MAX_BOXES-th box. A result sits in an output
// register; the next item is accepted while it waits. If the receiver still
// stalls when the following run ends, the block holds in its final step.
// Products run through a bit-serial multiplier, side and IoU quotients
// through a bit-serial divider. A truth load runs the two side divisions
// only; a predicted box adds the squarings when sqrt_mode is set, skips
// the area products and the IoU division when the boxes do not overlap,
// and skips the IoU division when the union is bad or the IoU saturates.
// result_valid rises at the end of the last box's busy time.
// Registers over APB: grid_side at 0x0, sqrt_mode at 0x4, always ready.
// Reset (synchronous, rst high) clears the run and truth box, sets
// grid_side to 7 and sqrt_mode to 1, and empties the output register.
module yolo_box_match_iou #(
  parameter int MAX_BOXES = ybm_pkg::MAX_BOXES_D
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_stall,
  input  ybm_pkg::item_t              item,
  output logic                        result_valid,
  input  logic                        result_stall,
  output ybm_pkg::result_t            result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ybm_pkg::ADDR_W-1:0]  paddr,
  input  logic [ybm_pkg::DATA_W-1:0]  pwdata,
  output logic [ybm_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import ybm_pkg::*;

  `include "yolo_box_match_iou_assert.svh"

  state_t state, state_next;

  logic [5:0] grid_side;
  logic       sqrt_mode;

  logic signed [15:0] truth_cx, truth_cy, truth_wd, truth_ht;
  logic [14:0] top_iou;
  logic [22:0] best_dist;
  logic [3:0]  best_idx;
  logic [3:0]  box_cnt;
  logic        uflag;
  logic        launched;

  logic               is_load, last;
  logic signed [15:0] bx, by, bw, bh;
  logic signed [15:0] px, py, pw, ph;
  logic [17:0]        ow, oh;
  logic [35:0]        inter4;
  logic signed [31:0] area_p, area_t;
  logic [33:0]        uden;
  logic [14:0]        cur_iou;
  logic [33:0]        acc;

  logic                mul_start, mul_busy, mul_done;
  logic [MUL_W-1:0]    mul_a, mul_b;
  logic [PROD_W-1:0]   prod;
  logic                div_start, div_busy, div_done;
  logic [DIV_R_W-1:0]  div_rem, div_den;
  logic [DIV_N_W-1:0]  div_num, quo;
  logic [STEP_W-1:0]   div_steps;

  logic               step_done;
  logic               item_acc;
  logic signed [18:0] ow_c, oh_c;
  logic signed [17:0] dx, dy, dw, dh;
  logic signed [32:0] area_sum;
  logic signed [37:0] union4;
  logic               union_bad, iou_sat;
  logic [15:0]        qsgn;
  logic [19:0]        dist_q;
  logic               by_iou, upd, emit, out_blocked, emit_go;
  logic [14:0]        iou_new;
  logic [3:0]         idx_new;
  logic [5:0]         side;

  ybm_mul u_mul (
    .clk, .rst, .start(mul_start), .a(mul_a), .b(mul_b),
    .busy(mul_busy), .done(mul_done), .prod
  );

  ybm_div u_div (
    .clk, .rst, .start(div_start), .rem_init(div_rem), .den(div_den),
    .num(div_num), .steps(div_steps), .busy(div_busy), .done(div_done), .quo
  );

  assign item_stall = (state != S_IDLE);
  assign item_acc   = item_valid && !item_stall;
  assign step_done  = launched && (mul_done || div_done);
  assign side       = (grid_side == '0) ? 6'd1 : grid_side;

  // config port
  assign pready = 1'b1;
  always_comb begin
    unique case (paddr[ADDR_W-1])
      REG_GRID_SIDE: prdata = DATA_W'(grid_side);
      REG_SQRT_MODE: prdata = DATA_W'(sqrt_mode);
      default:       prdata = '0;
    endcase
  end

  // geometry
  assign ow_c = ovl(px, pw, truth_cx, truth_wd);
  assign oh_c = ovl(py, ph, truth_cy, truth_ht);
  assign dx = {{2{px[15]}}, px} - {{2{truth_cx[15]}}, truth_cx};
  assign dy = {{2{py[15]}}, py} - {{2{truth_cy[15]}}, truth_cy};
  assign dw = {{2{pw[15]}}, pw} - {{2{truth_wd[15]}}, truth_wd};
  assign dh = {{2{ph[15]}}, ph} - {{2{truth_ht[15]}}, truth_ht};

  assign area_sum  = {area_p[31], area_p} + {area_t[31], area_t};
  assign union4    = {{3{area_sum[32]}}, area_sum, 2'b00} - {2'b00, inter4};
  assign union_bad = union4[37] || (union4 == '0);
  assign iou_sat   = {2'b00, inter4} >= {union4[36:0], 1'b0};

  // sign back onto a side quotient
  assign qsgn = (state == S_DIVX) ? (bx[15] ? -quo[15:0] : quo[15:0])
                                  : (by[15] ? -quo[15:0] : quo[15:0]);

  // decision
  assign dist_q  = acc[33:14];
  assign by_iou  = (top_iou != '0) || (cur_iou != '0);
  assign upd     = by_iou ? (cur_iou > top_iou) : ({3'b000, dist_q} < best_dist);
  assign iou_new = (by_iou && upd) ? cur_iou : top_iou;
  assign idx_new = upd ? box_cnt : best_idx;
  assign emit    = last || (({1'b0, box_cnt} + 5'd1) >= 5'(MAX_BOXES));
  assign out_blocked = result_valid && result_stall;
  assign emit_go = (state == S_DECIDE) && emit && !out_blocked;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (item_acc) state_next = S_DIVX;
      S_DIVX:   if (step_done) state_next = S_DIVY;
      S_DIVY: begin
        if (step_done) begin
          if (is_load) state_next = S_IDLE;
          else if (sqrt_mode) state_next = S_SQW;
          else state_next = S_OVL;
        end
      end
      S_SQW:    if (step_done) state_next = S_SQH;
      S_SQH:    if (step_done) state_next = S_OVL;
      S_OVL:    state_next = (ow_c[18] || oh_c[18]) ? S_DX : S_MINT;
      S_MINT:   if (step_done) state_next = S_MPA;
      S_MPA:    if (step_done) state_next = S_MTA;
      S_MTA:    if (step_done) state_next = S_UNION;
      S_UNION:  state_next = (union_bad || iou_sat) ? S_DX : S_DIVQ;
      S_DIVQ:   if (step_done) state_next = S_DX;
      S_DX:     if (step_done) state_next = S_DY;
      S_DY:     if (step_done) state_next = S_DW;
      S_DW:     if (step_done) state_next = S_DH;
      S_DH:     if (step_done) state_next = S_DECIDE;
      S_DECIDE: if (!(emit && out_blocked)) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // unit launches and operands
  always_comb begin
    mul_start = 1'b0;
    div_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_rem   = '0;
    div_den   = DIV_R_W'(side);
    div_num   = '0;
    div_steps = SIDE_STEPS;
    unique case (state)
      S_DIVX: begin
        div_start = !launched;
        div_num   = DIV_N_W'(mag({{2{bx[15]}}, bx}));
      end
      S_DIVY: begin
        div_start = !launched;
        div_num   = DIV_N_W'(mag({{2{by[15]}}, by}));
      end
      S_DIVQ: begin
        div_start = !launched;
        div_rem   = inter4[34:1];
        div_den   = uden;
        div_num   = {inter4[0], {(DIV_N_W-1){1'b0}}};
        div_steps = IOU_STEPS;
      end
      S_SQW: begin
        mul_start = !launched;
        mul_a     = mag({{2{bw[15]}}, bw});
        mul_b     = mul_a;
      end
      S_SQH: begin
        mul_start = !launched;
        mul_a     = mag({{2{bh[15]}}, bh});
        mul_b     = mul_a;
      end
      S_MINT: begin
        mul_start = !launched;
        mul_a     = ow;
        mul_b     = oh;
      end
      S_MPA: begin
        mul_start = !launched;
        mul_a     = mag({{2{pw[15]}}, pw});
        mul_b     = mag({{2{ph[15]}}, ph});
      end
      S_MTA: begin
        mul_start = !launched;
        mul_a     = mag({{2{truth_wd[15]}}, truth_wd});
        mul_b     = mag({{2{truth_ht[15]}}, truth_ht});
      end
      S_DX: begin
        mul_start = !launched;
        mul_a     = mag(dx);
        mul_b     = mul_a;
      end
      S_DY: begin
        mul_start = !launched;
        mul_a     = mag(dy);
        mul_b     = mul_a;
      end
      S_DW: begin
        mul_start = !launched;
        mul_a     = mag(dw);
        mul_b     = mul_a;
      end
      S_DH: begin
        mul_start = !launched;
        mul_a     = mag(dh);
        mul_b     = mul_a;
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  // control and run state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      launched     <= 1'b0;
      grid_side    <= GRID_RESET;
      sqrt_mode    <= 1'b1;
      truth_cx     <= '0;
      truth_cy     <= '0;
      truth_wd     <= '0;
      truth_ht     <= '0;
      top_iou      <= '0;
      best_dist    <= DIST_START;
      best_idx     <= '0;
      box_cnt      <= '0;
      uflag        <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (mul_start || div_start) launched <= 1'b1;
      else if (step_done) launched <= 1'b0;

      if (psel && penable && pwrite && pready) begin
        unique case (paddr[ADDR_W-1])
          REG_GRID_SIDE: grid_side <= pwdata[5:0];
          REG_SQRT_MODE: sqrt_mode <= pwdata[0];
          default:       grid_side <= grid_side;
        endcase
      end

      if (emit_go) result_valid <= 1'b1;
      else if (result_valid && !result_stall) result_valid <= 1'b0;

      if (state == S_DIVY && step_done && is_load) begin
        truth_cx  <= px;
        truth_cy  <= qsgn;
        truth_wd  <= bw;
        truth_ht  <= bh;
        top_iou   <= '0;
        best_dist <= DIST_START;
        best_idx  <= '0;
        box_cnt   <= '0;
        uflag     <= 1'b0;
      end

      if (state == S_UNION && union_bad) uflag <= 1'b1;

      if (state == S_DECIDE && !(emit && out_blocked)) begin
        if (emit) begin
          top_iou      <= '0;
          best_dist    <= DIST_START;
          best_idx     <= '0;
          box_cnt      <= '0;
          uflag        <= 1'b0;
        end else begin
          top_iou  <= iou_new;
          best_idx <= idx_new;
          if (!by_iou && upd) best_dist <= {3'b000, dist_q};
          box_cnt <= box_cnt + 4'd1;
        end
      end
    end
  end

  // per-item datapath
  always_ff @(posedge clk) begin
    if (item_acc) begin
      is_load <= !item.op;
      last    <= item.last_box;
      bx      <= item.box_x;
      by      <= item.box_y;
      bw      <= item.box_w;
      bh      <= item.box_h;
    end
    if (emit_go) begin
      result.chosen_index       <= idx_new;
      result.best_overlap       <= iou_new;
      result.matched_by_overlap <= (iou_new != '0);
      result.bad_union          <= uflag;
    end
    if (step_done) begin
      unique case (state)
        S_DIVX: px <= qsgn;
        S_DIVY: begin
          py <= qsgn;
          pw <= bw;
          ph <= bh;
        end
        S_SQW:  pw <= (prod[35:29] != '0) ? 16'sd32767 : {1'b0, prod[28:14]};
        S_SQH:  ph <= (prod[35:29] != '0) ? 16'sd32767 : {1'b0, prod[28:14]};
        S_MINT: inter4 <= prod;
        S_MPA:  area_p <= (pw[15] ^ ph[15]) ? -prod[31:0] : prod[31:0];
        S_MTA:  area_t <= (truth_wd[15] ^ truth_ht[15]) ? -prod[31:0] : prod[31:0];
        S_DIVQ: cur_iou <= (quo[14:0] > ONE_Q14) ? ONE_Q14 : quo[14:0];
        S_DX:   acc <= prod[33:0];
        S_DY, S_DW, S_DH: acc <= acc + prod[33:0];
        default: acc <= acc;
      endcase
    end
    if (state == S_OVL) begin
      ow      <= ow_c[17:0];
      oh      <= oh_c[17:0];
      cur_iou <= '0;
    end
    if (state == S_UNION) begin
      uden <= union4[33:0];
      if (!union_bad && iou_sat) cur_iou <= ONE_Q14;
    end
  end

  `YBM_ASSERT_IMP(a_mul_free, mul_start, !mul_busy)
  `YBM_ASSERT_IMP(a_div_free, div_start, !div_busy)
  `YBM_ASSERT_IMP(a_iou_range, state == S_DECIDE, cur_iou <= ONE_Q14)
  `YBM_ASSERT_NXT(a_emit_shows, emit_go, result_valid)

endmodule

// File: dv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ybm_pkg::*;

  localparam int BOX_LIMIT = 16;
  localparam logic [ADDR_W-1:0] ADDR_GRID = ADDR_W'(0);
  localparam logic [ADDR_W-1:0] ADDR_SQRT = ADDR_W'(4);
  localparam logic OP_TRUTH = 1'b0;
  localparam logic OP_BOX   = 1'b1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  item_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  result_t result;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  yolo_box_match_iou uut (.*);

  always #5 clk = ~clk;

  // predictor copy of configuration and run state
  int unsigned side_cfg;
  bit sqrt_cfg;
  longint t_cx, t_cy, t_w, t_h;
  longint lead_iou, lead_dist;
  int unsigned lead_idx, box_cnt;
  bit union_bad;

  result_t match_queue[$];
  int error_count = 0;
  int idle_pct = 13;
  int hold_cycles = 0;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    error_count++;
  endtask

  function automatic longint sext(input logic [15:0] v);
    return longint'($signed(v));
  endfunction

  function automatic longint scale_down(input longint v);
    longint s;
    longint m;
    s = (side_cfg == 0) ? 1 : side_cfg;
    m = (v < 0 ? -v : v) / s;
    return v < 0 ? -m : m;
  endfunction

  function automatic longint sq14(input longint v);
    longint p;
    p = (v * v) >>> 14;
    return p > 32767 ? 32767 : p;
  endfunction

  function automatic longint span2(input longint c1, w1, c2, w2);
    longint l, r;
    l = (2*c1 - w1) > (2*c2 - w2) ? (2*c1 - w1) : (2*c2 - w2);
    r = (2*c1 + w1) < (2*c2 + w2) ? (2*c1 + w1) : (2*c2 + w2);
    return r - l;
  endfunction

  function automatic void restart_run();
    lead_iou = 0;
    lead_dist = 400 * 16384;
    lead_idx = 0;
    box_cnt = 0;
    union_bad = 0;
  endfunction

  function automatic void predict_match(input item_t it);
    longint px, py, pw, ph, ow, oh, inter, uni, q, iou, gap;
    int unsigned idx;
    result_t r;
    px = scale_down(sext(it.box_x));
    py = scale_down(sext(it.box_y));
    pw = sext(it.box_w);
    ph = sext(it.box_h);
    if (it.op == OP_TRUTH) begin
      t_cx = px; t_cy = py; t_w = pw; t_h = ph;
      restart_run();
      return;
    end
    if (sqrt_cfg) begin
      pw = sq14(pw);
      ph = sq14(ph);
    end
    idx = box_cnt & 15;
    iou = 0;
    ow = span2(px, pw, t_cx, t_w);
    oh = span2(py, ph, t_cy, t_h);
    if (ow >= 0 && oh >= 0) begin
      inter = ow * oh;
      uni = 4 * (pw * ph + t_w * t_h) - inter;
      if (uni <= 0) union_bad = 1;
      else begin
        q = (inter <<< 14) / uni;
        iou = q > 16384 ? 16384 : q;
      end
    end
    gap = ((px-t_cx)*(px-t_cx) + (py-t_cy)*(py-t_cy) + (pw-t_w)*(pw-t_w)
           + (ph-t_h)*(ph-t_h)) >>> 14;
    if (lead_iou > 0 || iou > 0) begin
      if (iou > lead_iou) begin
        lead_iou = iou;
        lead_idx = idx;
      end
    end else if (gap < lead_dist) begin
      lead_dist = gap;
      lead_idx = idx;
    end
    if (it.last_box || idx + 1 >= BOX_LIMIT) begin
      r.chosen_index = 4'(lead_idx);
      r.best_overlap = 15'(lead_iou);
      r.matched_by_overlap = lead_iou > 0;
      r.bad_union = union_bad;
      match_queue.insert(match_queue.size(), r);
      restart_run();
    end else box_cnt = idx + 1;
  endfunction

  task automatic send_item(input item_t it);
    while ($urandom_range(99) < idle_pct) @(posedge clk);
    item <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    predict_match(it);
    item_valid <= 1'b0;
    // block stays busy after accepting any request
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [ADDR_W-1:0] a, input logic [DATA_W-1:0] d);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= a; pwdata <= d; penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (a == ADDR_GRID) side_cfg = d[5:0];
    else sqrt_cfg = d[0];
    @(posedge clk);
  endtask

  // waits for outstanding results plus one worst-case box time
  task automatic drain();
    while (match_queue.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  function automatic item_t make_box(input bit last, input int spread);
    item_t it;
    it.op = OP_BOX;
    it.box_x = 16'($signed($urandom_range(2*spread)) - spread);
    it.box_y = 16'($signed($urandom_range(2*spread)) - spread);
    it.box_w = 16'($urandom_range(spread));
    it.box_h = 16'($urandom_range(spread));
    it.last_box = last;
    return it;
  endfunction

  function automatic item_t make_truth(input int spread);
    item_t it;
    it = make_box(1'b0, spread);
    it.op = OP_TRUTH;
    it.last_box = $urandom_range(1);
    return it;
  endfunction

  task automatic test_directed();
    item_t it;
    send_item('{OP_TRUTH, 16'sd8192, 16'sd8192, 16'sd4096, 16'sd4096, 1'b1});
    send_item('{OP_BOX, 16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192, 1'b0});
    send_item('{OP_BOX, -16'sd32768, 16'sd32767, 16'sd100, 16'sd100, 1'b1});
    // overlap negative for the first box, which is scored by distance; the second box overlaps
    send_item('{OP_BOX, 16'sd32767, 16'sd32767, 16'sd10, 16'sd10, 1'b0});
    send_item('{OP_BOX, -16'sd32768, -16'sd32768, -16'sd32768, 16'sd32767, 1'b1});
    // truth with negative sizes: the overlap comes out negative, so no union is formed
    send_item('{OP_TRUTH, 16'sd0, 16'sd0, -16'sd4000, -16'sd4000, 1'b0});
    send_item('{OP_BOX, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1});
    // truth load mid-run discards the run
    send_item('{OP_TRUTH, 16'sd0, 16'sd0, 16'sd16384, 16'sd16384, 1'b0});
    send_item('{OP_BOX, 16'sd0, 16'sd0, 16'sd16384, 16'sd16384, 1'b0});
    send_item('{OP_TRUTH, 16'sd0, 16'sd0, 16'sd16384, 16'sd16384, 1'b1});
    // run too long: sixteen boxes without last
    for (int i = 0; i < 16; i++) begin
      it = make_box(1'b0, 20000);
      send_item(it);
    end
    drain();
  endtask

  task automatic test_config_sweep();
    item_t it;
    int sides[6] = '{0, 1, 32, 33, 63, 7};
    foreach (sides[k]) begin
      write_reg(ADDR_GRID, DATA_W'(sides[k]));
      write_reg(ADDR_SQRT, DATA_W'(k % 2));
      for (int r = 0; r < 4; r++) begin
        send_item(make_truth(32767));
        for (int b = 0; b < 4; b++) begin
          it = make_box(b == 3, (r == 0) ? 32767 : 16384);
          send_item(it);
        end
      end
      drain();
    end
  endtask

  task automatic test_random(input int n_items);
    item_t it;
    int n, len, spread;
    n = 0;
    while (n < n_items) begin
      spread = $urandom_range(3) == 0 ? 32767 : 12000;
      if ($urandom_range(9) == 0) begin
        it.op = 1'($urandom_range(1));
        it.box_x = 16'($urandom); it.box_y = 16'($urandom);
        it.box_w = 16'($urandom); it.box_h = 16'($urandom);
        it.last_box = 1'($urandom_range(1));
        send_item(it);
        n++;
      end else begin
        send_item(make_truth(spread));
        len = $urandom_range(12) == 0 ? 17 : $urandom_range(1, 6);
        for (int b = 0; b < len; b++) begin
          send_item(make_box(b == len - 1, spread));
        end
        n += len + 1;
      end
      if (n > n_items / 2 && n < n_items / 2 + 60) idle_pct = 0;
      else idle_pct = 13;
    end
  endtask

  task automatic test_backpressure();
    hold_cycles = 3000;
    for (int r = 0; r < 4; r++) begin
      send_item(make_truth(12000));
      send_item(make_box(1'b1, 12000));
    end
    drain();
  endtask

  // receiver stall and result checking
  always @(posedge clk) begin
    if (rst) result_stall <= 1'b0;
    else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      result_stall <= 1'b1;
    end else result_stall <= ($urandom_range(99) < idle_pct);
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (match_queue.size() == 0) begin
        report_mismatch("unexpected result", result, 0);
      end else begin
        want = match_queue.pop_front();
        if (result.chosen_index != want.chosen_index)
          report_mismatch("chosen_index", result.chosen_index, want.chosen_index);
        if (result.best_overlap != want.best_overlap)
          report_mismatch("best_overlap", result.best_overlap, want.best_overlap);
        if (result.matched_by_overlap != want.matched_by_overlap)
          report_mismatch("matched_by_overlap", result.matched_by_overlap,
                          want.matched_by_overlap);
        if (result.bad_union != want.bad_union)
          report_mismatch("bad_union", result.bad_union, want.bad_union);
      end
    end
  end

  initial begin
    side_cfg = GRID_RESET;
    sqrt_cfg = 1'b1;
    t_cx = 0; t_cy = 0; t_w = 0; t_h = 0;
    restart_run();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_config_sweep();
    test_backpressure();
    test_random(950);
    drain();
    if (match_queue.size() != 0) report_mismatch("results missing", match_queue.size(), 0);
    if (error_count == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end

  initial begin
    #20ms;
    $display("testbench: done, errors");
    $finish;
  end
endmodule

// File: files.f
+incdir+rtl/core
rtl/core/ybm_pkg.sv
rtl/core/ybm_mul.sv
rtl/core/ybm_div.sv
rtl/core/yolo_box_match_iou.sv
dv/testbench.sv
